>>> rtl/bcmf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binarize and cross median filter.
// No dependencies; imported by the line store, the result queue, the checker and the top level.

package bcmf_pkg;

   // Default for the largest supported frame side.
   localparam int MAX_SIDE_DEFAULT = 64;

   // Fixed field widths.
   localparam int PIX_W      = 8;
   localparam int CFG_SIDE_W = 7;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd2;

   // Register reset values.
   localparam logic [CFG_SIDE_W-1:0] IMAGE_WIDTH_RESET    = 7'd64;
   localparam logic [CFG_SIDE_W-1:0] IMAGE_HEIGHT_RESET   = 7'd64;
   localparam logic [PIX_W-1:0]      DARK_THRESHOLD_RESET = 8'd128;

   // Result queue sizing: one request causes at most three results.
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             filtered_bit;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_done;
   } result_type;

   // Line values at the column of the next pixel and the one to its right.
   typedef struct packed {
      logic mid_c;
      logic up_c;
      logic mid_r;
   } line_tap_type;

endpackage

>>> rtl/binarize_cross_median_filter_unit.sv
`timescale 1ns / 1ps
// Binarize and five-point cross median filter, top level (uses bcmf_pkg, bcmf_line_store,
// bcmf_result_queue). Pixels enter in raster order, one request per clock while req_stall is
// low; each is held in an input register until processed, thresholded (at or below
// dark_threshold gives 1), and voted against its up, down, left and right neighbours, with
// anything outside the configured frame counting as 0. A pixel's result appears once the
// pixel below it has arrived, so results run one row behind the input; on the last row each
// pixel also releases the result to its left, and the final pixel releases itself with
// frame_done set. Every result carries its row and column. The rate is one pixel per clock
// on all rows but the last while rsp_stall is low; there the single result port takes two
// results per pixel (three for the final pixel) and sets the pace; a four-entry result queue
// absorbs the bursts and req_stall holds the input when it lacks room. Width and height of 0
// act as 1 and sizes above MAX_SIDE act as MAX_SIDE. Write the csr registers only while no
// pixel is in flight; csr_ready is always high and writes to an unused index are dropped.

module binarize_cross_median_filter_unit
   import bcmf_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel requests
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_value,
   // filtered results
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_filtered_bit,
   output logic [POS_W-1:0]      rsp_out_row,
   output logic [POS_W-1:0]      rsp_out_col,
   output logic                  rsp_frame_done,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = CNT_W + 1;
   localparam int CMP_W  = (SIDE_W > CFG_SIDE_W) ? SIDE_W : CFG_SIDE_W;

   function automatic logic vote5(input logic a, input logic b, input logic c,
                                  input logic d, input logic e);
      logic [2:0] sum;
      sum = 3'(a) + 3'(b) + 3'(c) + 3'(d) + 3'(e);
      return (sum >= 3'd3);
   endfunction

   // Configuration registers.
   logic [CFG_SIDE_W-1:0] width_ff, height_ff;
   logic [PIX_W-1:0]      thr_ff;

   // Input register.
   logic             in_v_ff;
   logic [PIX_W-1:0] in_pix_ff;

   // Scan position and short history of the current row.
   logic [CNT_W-1:0] row_ff, col_ff;
   logic             left_ff;   // row above, one column to the left
   logic             bp1_ff;    // this row, one column to the left
   logic             bp2_ff;    // this row, two columns to the left

   logic [CMP_W-1:0]  w_cfg, h_cfg, w_eff, h_eff;
   logic              last_col, last_row;
   logic              has_up, has_left, has_left2;
   logic              pix_bit;
   logic              centre, up, right, left;
   logic              pa, pb, pc;
   logic [RES_CNT_W-1:0] res_count, push_count;
   logic              fire, take;
   logic [CNT_W-1:0]  next_col, next_row;
   logic [SIDE_W-1:0] right_addr;
   logic              right_ok;

   result_type        res_a, res_b, res_c, head;
   result_type        push_item [MAX_RESULTS];
   logic [QUEUE_CNT_W-1:0] space;
   line_tap_type      tap;

   // Register writes: accept every cycle, drop unknown indexes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
         thr_ff    <= DARK_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:    width_ff  <= csr_wdata[CFG_SIDE_W-1:0];
            REG_IMAGE_HEIGHT:   height_ff <= csr_wdata[CFG_SIDE_W-1:0];
            REG_DARK_THRESHOLD: thr_ff    <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Clamp the frame size and decode the scan position.
   always_comb begin
      w_cfg = CMP_W'(width_ff);
      h_cfg = CMP_W'(height_ff);
      if (w_cfg == '0) begin
         w_eff = CMP_W'(1);
      end else if (w_cfg > CMP_W'(MAX_SIDE)) begin
         w_eff = CMP_W'(MAX_SIDE);
      end else begin
         w_eff = w_cfg;
      end
      if (h_cfg == '0) begin
         h_eff = CMP_W'(1);
      end else if (h_cfg > CMP_W'(MAX_SIDE)) begin
         h_eff = CMP_W'(MAX_SIDE);
      end else begin
         h_eff = h_cfg;
      end

      last_col  = (CMP_W'(col_ff) + CMP_W'(1)) >= w_eff;
      last_row  = (CMP_W'(row_ff) + CMP_W'(1)) >= h_eff;
      has_up    = (row_ff != '0);
      has_left  = (col_ff != '0);
      has_left2 = (col_ff >= CNT_W'(2));
   end

   // Threshold and gather the cross around the pixel one row up.
   always_comb begin
      pix_bit = (in_pix_ff <= thr_ff);
      centre  = has_up & tap.mid_c;
      up      = has_up & tap.up_c;
      right   = has_up & !last_col & tap.mid_r;
      left    = has_up & has_left & left_ff;
   end

   // Build the results of this pixel in output order.
   always_comb begin
      pa = has_up;
      pb = last_row && has_left;
      pc = last_row && last_col;

      res_a.filtered_bit = vote5(centre, up, right, left, pix_bit);
      res_a.out_row      = POS_W'(row_ff - CNT_W'(1));
      res_a.out_col      = POS_W'(col_ff);
      res_a.frame_done   = 1'b0;

      // Left neighbour on the last row: its down neighbour is outside the frame.
      res_b.filtered_bit = vote5(bp1_ff, left_ff, has_left2 & bp2_ff, pix_bit, 1'b0);
      res_b.out_row      = POS_W'(row_ff);
      res_b.out_col      = POS_W'(col_ff - CNT_W'(1));
      res_b.frame_done   = 1'b0;

      // Final pixel of the frame: no right or down neighbour.
      res_c.filtered_bit = vote5(pix_bit, centre, has_left & bp1_ff, 1'b0, 1'b0);
      res_c.out_row      = POS_W'(row_ff);
      res_c.out_col      = POS_W'(col_ff);
      res_c.frame_done   = 1'b1;

      push_item[0] = pa ? res_a : (pb ? res_b : res_c);
      push_item[1] = (pa && pb) ? res_b : res_c;
      push_item[2] = res_c;

      res_count = RES_CNT_W'(pa) + RES_CNT_W'(pb) + RES_CNT_W'(pc);
   end

   // Process the held pixel once the queue has room for all of its results.
   assign fire       = in_v_ff && (space >= QUEUE_CNT_W'(res_count));
   assign push_count = fire ? res_count : '0;
   assign req_stall  = in_v_ff && !fire;
   assign take       = req_valid && !req_stall;

   always_comb begin
      next_col   = last_col ? '0 : (col_ff + CNT_W'(1));
      next_row   = last_col ? (last_row ? '0 : (row_ff + CNT_W'(1))) : row_ff;
      right_addr = SIDE_W'(next_col) + SIDE_W'(1);
      right_ok   = (right_addr < SIDE_W'(MAX_SIDE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (take) begin
         in_v_ff <= 1'b1;
      end else if (fire) begin
         in_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_pix_ff <= req_pixel_value;
      end
   end

   // Advance the scan position; drop the row history at the end of a row.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         left_ff <= 1'b0;
      end else if (fire) begin
         row_ff  <= next_row;
         col_ff  <= next_col;
         left_ff <= last_col ? 1'b0 : centre;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         bp2_ff <= bp1_ff;
         bp1_ff <= pix_bit;
      end
   end

   // Store this pixel and move the row above down one line; prefetch the
   // next pixel's column and its right neighbour.
   bcmf_line_store #(
      .MAX_SIDE (MAX_SIDE)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .wr_addr   (col_ff),
      .wr_mid    (pix_bit),
      .wr_up     (centre),
      .rd_a_addr (next_col),
      .rd_b_addr (right_addr[CNT_W-1:0]),
      .rd_b_ok   (right_ok),
      .tap       (tap)
   );

   bcmf_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_item  (push_item),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .head       (head)
   );

   assign rsp_filtered_bit = head.filtered_bit;
   assign rsp_out_row      = head.out_row;
   assign rsp_out_col      = head.out_col;
   assign rsp_frame_done   = head.frame_done;

endmodule

>>> rtl/bcmf_line_store.sv
`timescale 1ns / 1ps
// Two one-bit line memories (previous row and the row before it) with registered reads.
// Depends on bcmf_pkg for the tap struct.

module bcmf_line_store
   import bcmf_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [$clog2(MAX_SIDE)-1:0] wr_addr,
   input  logic                        wr_mid,
   input  logic                        wr_up,
   input  logic [$clog2(MAX_SIDE)-1:0] rd_a_addr,
   input  logic [$clog2(MAX_SIDE)-1:0] rd_b_addr,
   input  logic                        rd_b_ok,
   output line_tap_type                tap
);

   logic                mid_mem [MAX_SIDE];
   logic                up_mem  [MAX_SIDE];
   logic [MAX_SIDE-1:0] vld_ff;

   logic a_mid_ff, a_up_ff, b_mid_ff;
   logic fwd_mid_ff, fwd_up_ff;
   logic a_vld_ff, a_hit_ff, b_vld_ff, b_hit_ff;

   // Memory write and registered reads.
   always_ff @(posedge clock) begin
      if (step) begin
         mid_mem[wr_addr] <= wr_mid;
         up_mem[wr_addr]  <= wr_up;
         a_mid_ff         <= mid_mem[rd_a_addr];
         a_up_ff          <= up_mem[rd_a_addr];
         b_mid_ff         <= mid_mem[rd_b_addr];
         fwd_mid_ff       <= wr_mid;
         fwd_up_ff        <= wr_up;
      end
   end

   // Entries never written read as zero; a read of the entry written on the
   // same edge takes the new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         a_vld_ff <= 1'b0;
         a_hit_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         b_hit_ff <= 1'b0;
      end else if (step) begin
         vld_ff[wr_addr] <= 1'b1;
         a_vld_ff        <= vld_ff[rd_a_addr];
         a_hit_ff        <= (rd_a_addr == wr_addr);
         b_vld_ff        <= rd_b_ok && vld_ff[rd_b_addr];
         b_hit_ff        <= rd_b_ok && (rd_b_addr == wr_addr);
      end
   end

   always_comb begin
      tap.mid_c = a_hit_ff ? fwd_mid_ff : (a_vld_ff & a_mid_ff);
      tap.up_c  = a_hit_ff ? fwd_up_ff  : (a_vld_ff & a_up_ff);
      tap.mid_r = b_hit_ff ? fwd_mid_ff : (b_vld_ff & b_mid_ff);
   end

endmodule

>>> rtl/bcmf_result_queue.sv
`timescale 1ns / 1ps
// Small shifting result queue: takes up to three results per cycle, drains one.
// Depends on bcmf_pkg for the result struct and queue sizing.

module bcmf_result_queue
   import bcmf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RES_CNT_W-1:0]   push_count,
   input  result_type             push_item [MAX_RESULTS],
   output logic [QUEUE_CNT_W-1:0] space,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output result_type             head
);

   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in, base;
   result_type             slot_ff  [QUEUE_DEPTH];
   result_type             slot_in  [QUEUE_DEPTH];
   result_type             shifted  [QUEUE_DEPTH];
   logic                   pop;

   always_comb begin
      pop  = (cnt_ff != '0) && !rsp_stall;
      base = cnt_ff - QUEUE_CNT_W'(pop);

      // Advance the queue by one on a pop.
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = pop ? slot_ff[i + 1] : slot_ff[i];
      end
      shifted[QUEUE_DEPTH-1] = slot_ff[QUEUE_DEPTH-1];

      // Append new results right behind the surviving ones.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         logic [QUEUE_CNT_W-1:0] m;
         m          = QUEUE_CNT_W'(i) - base;
         slot_in[i] = shifted[i];
         if (QUEUE_CNT_W'(i) >= base && m < QUEUE_CNT_W'(push_count)) begin
            case (m[RES_CNT_W-1:0])
               2'd0:    slot_in[i] = push_item[0];
               2'd1:    slot_in[i] = push_item[1];
               default: slot_in[i] = push_item[2];
            endcase
         end
      end

      cnt_in = base + QUEUE_CNT_W'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign space     = QUEUE_CNT_W'(QUEUE_DEPTH) - cnt_ff;
   assign rsp_valid = (cnt_ff != '0);
   assign head      = slot_ff[0];

endmodule

>>> rtl/bcmf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the binarize and cross median filter, bound to the top level.
// Depends on bcmf_pkg for field widths.

module bcmf_checker
   import bcmf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_filtered_bit,
   input logic [POS_W-1:0] rsp_out_row,
   input logic [POS_W-1:0] rsp_out_col,
   input logic             rsp_frame_done
);

   // A stalled result stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_filtered_bit, rsp_out_row, rsp_out_col, rsp_frame_done}))
      else $error("stalled result changed");

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Results start only after a request was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without a matching request");

   // Stall only while a request is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(req_valid && !req_stall) || $past(req_stall))
      else $error("request stalled with nothing held");

endmodule

bind binarize_cross_median_filter_unit bcmf_checker u_bcmf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_filtered_bit (rsp_filtered_bit),
   .rsp_out_row      (rsp_out_row),
   .rsp_out_col      (rsp_out_col),
   .rsp_frame_done   (rsp_frame_done)
);
